>>> design/tdpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpp_pkg
// Shared constants, register indexes and types of the trapezoidal distance
// PWM profile block.
// ----------------------------------------------------------------------------
package tdpp_pkg;

   localparam int DIST_BITS       = 24;
   localparam int PWM_BITS        = 16;
   localparam int DIR_BITS        = 2;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int START_PWM_RESET = 1280;

   localparam logic [CSR_INDEX_BITS-1:0] REG_DIRECTION       = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TARGET_DISTANCE = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PEAK_PWM        = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ACCEL_DISTANCE  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DECEL_DISTANCE  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_START_PWM       = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SA_WAIT,
      ST_SD_WAIT,
      ST_DECIDE,
      ST_RAMP_WAIT,
      ST_LEVEL,
      ST_FINISH
   } prof_state_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV
   } muldiv_state_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic rem_nz;
   } muldiv_status_type;

endpackage

>>> design/tdpp_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpp_muldiv
// Bit-serial multiply then divide: floor(mcand * mplier / divisor), one
// multiplier bit and then one quotient bit per cycle, with a remainder flag.
// ----------------------------------------------------------------------------
module tdpp_muldiv #(
   parameter int DIST_BITS = tdpp_pkg::DIST_BITS,
   parameter int ARG_BITS  = tdpp_pkg::DIST_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ARG_BITS-1:0]           mcand,
   input  logic [DIST_BITS-1:0]          mplier,
   input  logic [DIST_BITS:0]            divisor,
   output logic [ARG_BITS-1:0]           quotient,
   output tdpp_pkg::muldiv_status_type   status
);

   localparam int MAX_BITS = (ARG_BITS > DIST_BITS) ? ARG_BITS : DIST_BITS;
   localparam int CW       = $clog2(MAX_BITS);

   tdpp_pkg::muldiv_state_type state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [ARG_BITS-1:0]       mcand_ff, mcand_in;
   logic [DIST_BITS:0]        div_ff, div_in;
   logic [ARG_BITS-1:0]       hi_ff, hi_in;
   logic [DIST_BITS-1:0]      lo_ff, lo_in;
   logic [DIST_BITS:0]        rem_ff, rem_in;
   logic [ARG_BITS-1:0]       qsh_ff, qsh_in;
   logic                      done_ff, done_in;

   logic [ARG_BITS:0]              acc;
   logic [ARG_BITS+DIST_BITS-1:0]  prod_next;
   logic [DIST_BITS+1:0]           trial;
   logic [DIST_BITS+1:0]           dsub;
   logic                           ge;

   assign acc       = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);
   assign prod_next = {acc, lo_ff[DIST_BITS-1:1]};
   assign trial     = {rem_ff, qsh_ff[ARG_BITS-1]};
   assign ge        = trial >= {1'b0, div_ff};
   assign dsub      = trial - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tdpp_pkg::MD_IDLE;
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      div_ff   <= div_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      rem_ff   <= rem_in;
      qsh_ff   <= qsh_in;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      mcand_in = mcand_ff;
      div_in   = div_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      rem_in   = rem_ff;
      qsh_in   = qsh_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         tdpp_pkg::MD_IDLE: begin
            if (start) begin
               mcand_in = mcand;
               div_in   = divisor;
               hi_in    = '0;
               lo_in    = mplier;
               count_in = CW'(DIST_BITS - 1);
               state_in = tdpp_pkg::MD_MUL;
            end
         end
         tdpp_pkg::MD_MUL: begin
            hi_in = acc[ARG_BITS:1];
            lo_in = {acc[0], lo_ff[DIST_BITS-1:1]};
            if (count_ff == '0) begin
               // high part of the product seeds the remainder
               rem_in   = {1'b0, prod_next[ARG_BITS+DIST_BITS-1:ARG_BITS]};
               qsh_in   = prod_next[ARG_BITS-1:0];
               count_in = CW'(ARG_BITS - 1);
               state_in = tdpp_pkg::MD_DIV;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         tdpp_pkg::MD_DIV: begin
            rem_in = ge ? dsub[DIST_BITS:0] : trial[DIST_BITS:0];
            qsh_in = {qsh_ff[ARG_BITS-2:0], ge};
            if (count_ff == '0) begin
               done_in  = 1'b1;
               state_in = tdpp_pkg::MD_IDLE;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            state_in = tdpp_pkg::MD_IDLE;
         end
      endcase
   end

   assign quotient      = qsh_ff;
   assign status.busy   = (state_ff != tdpp_pkg::MD_IDLE);
   assign status.done   = done_ff;
   assign status.rem_nz = (rem_ff != '0);

endmodule

>>> design/trapezoidal_distance_pwm_profile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoidal_distance_pwm_profile
// Distance-driven trapezoidal PWM profile: ramps up from the start PWM, cruises
// at the peak and ramps down before the target distance, then stops.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_tvalid/req_tready  | tuser start_req, tdata odometry
//   rsp     | out       | rsp_tvalid/rsp_tready  | tdata pwm, direction; tuser flags
//   csr     | in        | csr_we                 | csr_index, csr_wdata
//
// idle and stop ticks pass through EVAL and FINISH before rsp_tvalid is registered, cruise
// ticks through EVAL, DECIDE and FINISH; scaling the zones adds two passes of the shared
// bit-serial multiply/divide unit and a ramp adds one pass plus the LEVEL state, so the
// worst tick takes three passes
// synchronous active-high reset, no clearing pass
// a result waiting on rsp_tready holds the next request in its finish step
// ----------------------------------------------------------------------------
module trapezoidal_distance_pwm_profile #(
   parameter int DIST_BITS = tdpp_pkg::DIST_BITS,
   parameter int PWM_BITS  = tdpp_pkg::PWM_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((DIST_BITS+7)/8)*8-1:0]      req_tdata,  // odometry_distance
   input  logic                                req_tuser,  // start_req
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((PWM_BITS+9)/8)*8-1:0]       rsp_tdata,  // pwm_level, move_direction
   output logic [1:0]                          rsp_tuser,  // stop_now, running
   // configuration
   input  logic                                csr_we,
   input  logic [tdpp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [((DIST_BITS > PWM_BITS) ? DIST_BITS : PWM_BITS)-1:0] csr_wdata
);

   localparam int AW         = (DIST_BITS > PWM_BITS) ? DIST_BITS : PWM_BITS;
   localparam int LW         = AW + 1;
   localparam int DW         = tdpp_pkg::DIR_BITS;
   localparam int RSP_DATA_W = ((PWM_BITS + 9) / 8) * 8;

   // configuration registers
   logic [DW-1:0]        direction_ff;
   logic [DIST_BITS-1:0] target_ff;
   logic [PWM_BITS-1:0]  peak_ff;
   logic [DIST_BITS-1:0] accel_ff;
   logic [DIST_BITS-1:0] decel_ff;
   logic [PWM_BITS-1:0]  start_pwm_ff;

   tdpp_pkg::prof_state_type state_ff, state_in;
   logic                   active_ff, active_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DIST_BITS+1:0]   travelled_ff, travelled_in;
   logic [DIST_BITS-1:0]   remaining_ff, remaining_in;
   logic [DIST_BITS-1:0]   sa_ff, sa_in;
   logic [DIST_BITS-1:0]   sd_ff, sd_in;
   logic [AW-1:0]          q_ff, q_in;
   logic                   nz_ff, nz_in;
   logic [PWM_BITS-1:0]    pwm_res_ff, pwm_res_in;
   logic                   stop_res_ff, stop_res_in;
   logic [PWM_BITS-1:0]    rsp_pwm_ff, rsp_pwm_in;
   logic [DW-1:0]          rsp_dir_ff, rsp_dir_in;
   logic                   rsp_stop_ff, rsp_stop_in;
   logic                   rsp_run_ff, rsp_run_in;

   logic                          md_start;
   logic [AW-1:0]                 md_mcand;
   logic [DIST_BITS-1:0]          md_mplier;
   logic [DIST_BITS:0]            md_div;
   logic [AW-1:0]                 md_quot;
   tdpp_pkg::muldiv_status_type   md_status;

   logic [DIST_BITS:0]   zone_sum;
   logic                 rising;
   logic [PWM_BITS-1:0]  ramp_span;
   logic [LW-1:0]        q_ext;
   logic [LW-1:0]        start_ext;
   logic [LW-1:0]        peak_ext;
   logic [LW-1:0]        up_lvl;
   logic [LW-1:0]        q_ceil;
   logic [LW-1:0]        down_lvl;
   logic [LW-1:0]        raw_lvl;
   logic [LW-1:0]        lvl;

   assign zone_sum  = {1'b0, accel_ff} + {1'b0, decel_ff};
   assign rising    = peak_ff >= start_pwm_ff;
   assign ramp_span = rising ? (peak_ff - start_pwm_ff) : (start_pwm_ff - peak_ff);

   assign q_ext     = {1'b0, q_ff};
   assign start_ext = LW'(start_pwm_ff);
   assign peak_ext  = LW'(peak_ff);
   assign up_lvl    = start_ext + q_ext;
   assign q_ceil    = q_ext + LW'(nz_ff);
   assign down_lvl  = (q_ceil >= start_ext) ? '0 : (start_ext - q_ceil);
   assign raw_lvl   = rising ? up_lvl : down_lvl;
   assign lvl       = (raw_lvl > peak_ext) ? peak_ext : raw_lvl;

   tdpp_muldiv #(
      .DIST_BITS (DIST_BITS),
      .ARG_BITS  (AW)
   ) u_muldiv (
      .clock    (clock),
      .reset    (reset),
      .start    (md_start),
      .mcand    (md_mcand),
      .mplier   (md_mplier),
      .divisor  (md_div),
      .quotient (md_quot),
      .status   (md_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= '0;
         target_ff    <= '0;
         peak_ff      <= '0;
         accel_ff     <= '0;
         decel_ff     <= '0;
         start_pwm_ff <= PWM_BITS'(tdpp_pkg::START_PWM_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            tdpp_pkg::REG_DIRECTION:       direction_ff <= csr_wdata[DW-1:0];
            tdpp_pkg::REG_TARGET_DISTANCE: target_ff    <= csr_wdata[DIST_BITS-1:0];
            tdpp_pkg::REG_PEAK_PWM:        peak_ff      <= csr_wdata[PWM_BITS-1:0];
            tdpp_pkg::REG_ACCEL_DISTANCE:  accel_ff     <= csr_wdata[DIST_BITS-1:0];
            tdpp_pkg::REG_DECEL_DISTANCE:  decel_ff     <= csr_wdata[DIST_BITS-1:0];
            tdpp_pkg::REG_START_PWM:       start_pwm_ff <= csr_wdata[PWM_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tdpp_pkg::ST_IDLE;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      travelled_ff <= travelled_in;
      remaining_ff <= remaining_in;
      sa_ff        <= sa_in;
      sd_ff        <= sd_in;
      q_ff         <= q_in;
      nz_ff        <= nz_in;
      pwm_res_ff   <= pwm_res_in;
      stop_res_ff  <= stop_res_in;
      rsp_pwm_ff   <= rsp_pwm_in;
      rsp_dir_ff   <= rsp_dir_in;
      rsp_stop_ff  <= rsp_stop_in;
      rsp_run_ff   <= rsp_run_in;
   end

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      rsp_valid_in = rsp_valid_ff;
      travelled_in = travelled_ff;
      remaining_in = remaining_ff;
      sa_in        = sa_ff;
      sd_in        = sd_ff;
      q_in         = q_ff;
      nz_in        = nz_ff;
      pwm_res_in   = pwm_res_ff;
      stop_res_in  = stop_res_ff;
      rsp_pwm_in   = rsp_pwm_ff;
      rsp_dir_in   = rsp_dir_ff;
      rsp_stop_in  = rsp_stop_ff;
      rsp_run_in   = rsp_run_ff;
      req_tready   = 1'b0;
      md_start     = 1'b0;
      md_mcand     = AW'(accel_ff);
      md_mplier    = target_ff;
      md_div       = zone_sum;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         tdpp_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               active_in    = active_ff | req_tuser;
               // odometry times three
               travelled_in = {2'b00, req_tdata[DIST_BITS-1:0]}
                            + {1'b0, req_tdata[DIST_BITS-1:0], 1'b0};
               state_in     = tdpp_pkg::ST_EVAL;
            end
         end
         tdpp_pkg::ST_EVAL: begin
            pwm_res_in  = '0;
            stop_res_in = 1'b0;
            if (!active_ff) begin
               state_in = tdpp_pkg::ST_FINISH;
            end else if (travelled_ff >= {2'b00, target_ff}) begin
               stop_res_in = 1'b1;
               active_in   = 1'b0;
               state_in    = tdpp_pkg::ST_FINISH;
            end else begin
               remaining_in = target_ff - travelled_ff[DIST_BITS-1:0];
               if (zone_sum > {1'b0, target_ff}) begin
                  md_start = 1'b1;
                  state_in = tdpp_pkg::ST_SA_WAIT;
               end else begin
                  sa_in    = accel_ff;
                  sd_in    = decel_ff;
                  state_in = tdpp_pkg::ST_DECIDE;
               end
            end
         end
         tdpp_pkg::ST_SA_WAIT: begin
            if (md_status.done) begin
               sa_in    = md_quot[DIST_BITS-1:0];
               md_start = 1'b1;
               md_mcand = AW'(decel_ff);
               state_in = tdpp_pkg::ST_SD_WAIT;
            end
         end
         tdpp_pkg::ST_SD_WAIT: begin
            if (md_status.done) begin
               sd_in    = md_quot[DIST_BITS-1:0];
               state_in = tdpp_pkg::ST_DECIDE;
            end
         end
         tdpp_pkg::ST_DECIDE: begin
            md_mcand = AW'(ramp_span);
            if (travelled_ff < {2'b00, sa_ff}) begin
               md_start  = 1'b1;
               md_mplier = travelled_ff[DIST_BITS-1:0];
               md_div    = {1'b0, accel_ff};
               state_in  = tdpp_pkg::ST_RAMP_WAIT;
            end else if (remaining_ff < sd_ff) begin
               md_start  = 1'b1;
               md_mplier = remaining_ff;
               md_div    = {1'b0, decel_ff};
               state_in  = tdpp_pkg::ST_RAMP_WAIT;
            end else begin
               pwm_res_in = peak_ff;
               state_in   = tdpp_pkg::ST_FINISH;
            end
         end
         tdpp_pkg::ST_RAMP_WAIT: begin
            if (md_status.done) begin
               q_in     = md_quot;
               nz_in    = md_status.rem_nz;
               state_in = tdpp_pkg::ST_LEVEL;
            end
         end
         tdpp_pkg::ST_LEVEL: begin
            pwm_res_in = lvl[PWM_BITS-1:0];
            state_in   = tdpp_pkg::ST_FINISH;
         end
         tdpp_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_pwm_in   = pwm_res_ff;
               rsp_dir_in   = direction_ff;
               rsp_stop_in  = stop_res_ff;
               rsp_run_in   = active_ff;
               state_in     = tdpp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tdpp_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_dir_ff, rsp_pwm_ff});
   assign rsp_tuser  = {rsp_run_ff, rsp_stop_ff};

   // a stop result is idle and commands zero
   a_stop_is_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stop_ff |-> !rsp_run_ff && (rsp_pwm_ff == '0))
      else $error("stop result with running set or nonzero pwm");

   // the shared unit only finishes while a wait state expects it
   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      md_status.done |-> (state_ff == tdpp_pkg::ST_SA_WAIT)
                      || (state_ff == tdpp_pkg::ST_SD_WAIT)
                      || (state_ff == tdpp_pkg::ST_RAMP_WAIT))
      else $error("multiply/divide finished outside a wait state");

   // no new operation is started while one is in flight
   a_start_free: assert property (@(posedge clock) disable iff (reset)
      md_start |-> !md_status.busy)
      else $error("multiply/divide started while busy");

   // an accepted request moves straight to evaluation
   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == tdpp_pkg::ST_EVAL)
      else $error("accepted request not evaluated");

endmodule
